### rtl/sprb_pkg.sv
// Package for the system port register block: register map codes,
// configuration indexes, fixed read patterns and the result item type.
// No dependencies.
package sprb_pkg;

    // Register numbers, taken from address bits [3:1] of an odd address
    typedef enum logic [2:0] {
        REG_CONTRAST   = 3'd0,
        REG_SHIFT_3D   = 3'd1,
        REG_SPARE      = 3'd2,
        REG_CONTROL    = 3'd3,
        REG_IMAGE_UNIT = 3'd4,
        REG_MACHINE    = 3'd5,
        REG_SRAM_VER   = 3'd6,
        REG_POWER      = 3'd7
    } t_reg_sel;

    // Configuration register indexes
    localparam logic [1:0] CFG_MACHINE_TYPE  = 2'd0;
    localparam logic [1:0] CFG_VERSION_MAJOR = 2'd1;
    localparam logic [1:0] CFG_VERSION_MINOR = 2'd2;

    // Machine type codes
    localparam logic [1:0] MT_CLOCK_MODEL = 2'd1;
    localparam logic [1:0] MT_030_MODEL   = 2'd2;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Fixed read patterns and magic write values
    localparam logic [7:0] BYTE_IDLE      = 8'hff;
    localparam logic [7:0] CONTRAST_HIGH  = 8'hf0;
    localparam logic [7:0] SHIFT_HIGH     = 8'hf8;
    localparam logic [7:0] CONTROL_HIGH   = 8'hf0;
    localparam logic [7:0] MACHINE_CLOCK  = 8'hfe;
    localparam logic [7:0] MACHINE_030    = 8'hdc;
    localparam logic [7:0] SRAM_UNLOCK    = 8'h31;
    localparam logic [7:0] VERSION_START  = 8'h58;  // 'X'
    localparam logic [7:0] VERSION_TAG    = 8'h36;  // '6'
    localparam logic [3:0] POWER_NIB_ZERO = 4'h0;
    localparam logic [3:0] POWER_NIB_F    = 4'hf;
    localparam logic [7:0] WORD_HIGH      = 8'hff;

    // Sequence counter codes
    localparam logic [1:0] SEQ_IDLE  = 2'd0;
    localparam logic [1:0] SEQ_ONE   = 2'd1;
    localparam logic [1:0] SEQ_TWO   = 2'd2;
    localparam logic [1:0] SEQ_THREE = 2'd3;

    // One result item
    typedef struct packed {
        logic [15:0] read_data;
        logic        contrast_changed;
        logic        sram_enable_update;
        logic        sram_write_enable;
        logic        control_update;
        logic        keyboard_send_wait;
        logic        hrl_drive;
        logic        power_off;
    } t_result;

    // One input item
    typedef struct packed {
        logic       cmd;
        logic       word_access;
        logic [3:0] addr_low;
        logic [7:0] write_data;
        logic       keyboard_connected;
        logic       hrl_status;
    } t_access;

    // Machine type byte seen in register 5
    function automatic logic [7:0] machine_byte(input logic [1:0] mt);
        logic [7:0] b;
        case (mt)
            MT_CLOCK_MODEL: b = MACHINE_CLOCK;
            MT_030_MODEL:   b = MACHINE_030;
            default:        b = BYTE_IDLE;
        endcase
        return b;
    endfunction

endpackage

### rtl/system_port_register_block_top.sv
// System port register block: eight byte registers at odd addresses.
// One access item every cycle while the result side keeps up; each item passes
// an input register, one decode and update stage, and a result register.
// Depends on sprb_pkg.
module system_port_register_block_top
    import sprb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access item in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_word_access,
    input  logic [3:0]  i_addr_low,
    input  logic [7:0]  i_write_data,
    input  logic        i_keyboard_connected,
    input  logic        i_hrl_status,
    // result item out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic [3:0]  o_contrast_level,
    output logic        o_contrast_changed,
    output logic [1:0]  o_shift_3d,
    output logic [4:0]  o_image_unit_select,
    output logic        o_sram_enable_update,
    output logic        o_sram_write_enable,
    output logic        o_control_update,
    output logic        o_keyboard_send_wait,
    output logic        o_hrl_drive,
    output logic        o_power_off,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Every item is decoded combinationally; the block streams one access
    // per clock when the result side keeps up. The result is registered when
    // the item leaves the decode stage; a stalled result holds the decode stage
    // and with it the input. The visible settings (contrast, 3D shift, image
    // unit) are sampled with each result item.

    // configuration registers
    logic [1:0] r_machine_type;
    logic [7:0] r_version_major;
    logic [7:0] r_version_minor;

    // input stage
    logic       r_in_valid;
    t_access    r_in;

    // block state
    logic [3:0] r_contrast, n_contrast;
    logic [1:0] r_shift,    n_shift;
    logic [4:0] r_image,    n_image;
    logic [1:0] r_pwr_cnt,  n_pwr_cnt;
    logic [1:0] r_ver_cnt,  n_ver_cnt;

    // result stage
    logic       r_out_valid;
    t_result    r_out,     n_out;
    logic [3:0] r_out_contrast;
    logic [1:0] r_out_shift;
    logic [4:0] r_out_image;

    logic       advance;
    logic [3:0] addr;
    t_reg_sel   sel;
    logic       odd;
    logic [7:0] rd_byte;
    logic       wr;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Take configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_type  <= '0;
            r_version_major <= '0;
            r_version_minor <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MACHINE_TYPE:  r_machine_type  <= i_cfg_data[1:0];
                CFG_VERSION_MAJOR: r_version_major <= i_cfg_data;
                CFG_VERSION_MINOR: r_version_minor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted item until the decode stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.cmd                <= i_cmd;
            r_in.word_access        <= i_word_access;
            r_in.addr_low           <= i_addr_low;
            r_in.write_data         <= i_write_data;
            r_in.keyboard_connected <= i_keyboard_connected;
            r_in.hrl_status         <= i_hrl_status;
        end
    end

    // Decode the access, form the result and the next state
    always_comb begin
        addr = r_in.addr_low | {3'b000, r_in.word_access};
        odd  = addr[0];
        sel  = t_reg_sel'(addr[3:1]);
        wr   = (r_in.cmd == CMD_WRITE) && odd;

        n_contrast = r_contrast;
        n_shift    = r_shift;
        n_image    = r_image;
        n_pwr_cnt  = r_pwr_cnt;
        n_ver_cnt  = r_ver_cnt;
        n_out      = '0;
        rd_byte    = BYTE_IDLE;

        // read path
        if (r_in.cmd == CMD_READ && odd) begin
            case (sel)
                REG_CONTRAST: rd_byte = CONTRAST_HIGH | {4'h0, r_contrast};
                REG_SHIFT_3D: rd_byte = SHIFT_HIGH | {6'h00, r_shift};
                REG_CONTROL:  rd_byte = CONTROL_HIGH
                                      | {4'h0, r_in.keyboard_connected, 3'b000}
                                      | {6'h00, r_in.hrl_status, 1'b0};
                REG_MACHINE:  rd_byte = machine_byte(r_machine_type);
                REG_SRAM_VER: begin
                    case (r_ver_cnt)
                        SEQ_ONE: begin
                            rd_byte   = VERSION_TAG;
                            n_ver_cnt = SEQ_TWO;
                        end
                        SEQ_TWO: begin
                            rd_byte   = r_version_major;
                            n_ver_cnt = SEQ_THREE;
                        end
                        SEQ_THREE: begin
                            rd_byte   = r_version_minor;
                            n_ver_cnt = SEQ_IDLE;
                        end
                        default: rd_byte = BYTE_IDLE;
                    endcase
                end
                default: rd_byte = BYTE_IDLE;
            endcase
        end
        if (r_in.cmd == CMD_READ) begin
            n_out.read_data = r_in.word_access ? {WORD_HIGH, rd_byte} : {8'h00, rd_byte};
        end

        // write path
        if (wr) begin
            case (sel)
                REG_CONTRAST: begin
                    if (r_contrast != r_in.write_data[3:0]) begin
                        n_contrast             = r_in.write_data[3:0];
                        n_out.contrast_changed = 1'b1;
                    end
                end
                REG_SHIFT_3D:   n_shift = r_in.write_data[1:0];
                REG_CONTROL: begin
                    n_out.control_update     = 1'b1;
                    n_out.keyboard_send_wait = !r_in.write_data[3];
                    n_out.hrl_drive          = r_in.write_data[1];
                end
                REG_IMAGE_UNIT: n_image = r_in.write_data[4:0];
                REG_SRAM_VER: begin
                    n_out.sram_enable_update = 1'b1;
                    n_out.sram_write_enable  = (r_in.write_data == SRAM_UNLOCK);
                    n_ver_cnt = (r_in.write_data == VERSION_START) ? SEQ_ONE : SEQ_IDLE;
                end
                REG_POWER: begin
                    // advance the 0,F,F low-nibble detector; stick once complete
                    case (r_pwr_cnt)
                        SEQ_IDLE: n_pwr_cnt = (r_in.write_data[3:0] == POWER_NIB_ZERO)
                                            ? SEQ_ONE : SEQ_IDLE;
                        SEQ_ONE:  n_pwr_cnt = (r_in.write_data[3:0] == POWER_NIB_F)
                                            ? SEQ_TWO : SEQ_IDLE;
                        SEQ_TWO: begin
                            if (r_in.write_data[3:0] == POWER_NIB_F) begin
                                n_pwr_cnt       = SEQ_THREE;
                                n_out.power_off = 1'b1;
                            end else begin
                                n_pwr_cnt = SEQ_IDLE;
                            end
                        end
                        default: n_pwr_cnt = r_pwr_cnt;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Update block state as each item passes the decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast <= '0;
            r_shift    <= '0;
            r_image    <= '0;
            r_pwr_cnt  <= SEQ_IDLE;
            r_ver_cnt  <= SEQ_IDLE;
        end else if (advance) begin
            r_contrast <= n_contrast;
            r_shift    <= n_shift;
            r_image    <= n_image;
            r_pwr_cnt  <= n_pwr_cnt;
            r_ver_cnt  <= n_ver_cnt;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out          <= n_out;
            r_out_contrast <= n_contrast;
            r_out_shift    <= n_shift;
            r_out_image    <= n_image;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_read_data          = r_out.read_data;
    assign o_contrast_level     = r_out_contrast;
    assign o_contrast_changed   = r_out.contrast_changed;
    assign o_shift_3d           = r_out_shift;
    assign o_image_unit_select  = r_out_image;
    assign o_sram_enable_update = r_out.sram_enable_update;
    assign o_sram_write_enable  = r_out.sram_write_enable;
    assign o_control_update     = r_out.control_update;
    assign o_keyboard_send_wait = r_out.keyboard_send_wait;
    assign o_hrl_drive          = r_out.hrl_drive;
    assign o_power_off          = r_out.power_off;

    // A completed power sequence stays complete until reset
    a_power_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pwr_cnt == SEQ_THREE |=> r_pwr_cnt == SEQ_THREE)
        else $error("power sequence left its final count");

    // A power-off result implies the detector reached its final count
    a_power_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_power_off |-> r_pwr_cnt == SEQ_THREE)
        else $error("power_off without completed sequence");

    // At most one update strobe per result item
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_contrast_changed, o_sram_enable_update,
                                  o_control_update, o_power_off}))
        else $error("several update strobes in one item");

    // A non-'X' write to register 6 ends any version read sequence
    a_version_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && wr && sel == REG_SRAM_VER && r_in.write_data != VERSION_START
        |=> r_ver_cnt == SEQ_IDLE)
        else $error("version sequence survived a register 6 write");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for system_port_register_block_top: directed and random
// bus accesses over several configuration and idling phases, checked per field.
// Depends on sprb_pkg and the block's RTL.
module tb;
    import sprb_pkg::*;

    // Machine type codes with no name in the package
    localparam logic [1:0] MT_DISK_MODEL  = 2'd0;
    localparam logic [1:0] MT_SPARE_MODEL = 2'd3;

    // Everything the block reports for one access
    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  contrast_level;
        logic        contrast_changed;
        logic [1:0]  shift_3d;
        logic [4:0]  image_unit_select;
        logic        sram_enable_update;
        logic        sram_write_enable;
        logic        control_update;
        logic        keyboard_send_wait;
        logic        hrl_drive;
        logic        power_off;
    } t_port_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_access     held_access = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_read_data;
    logic [3:0]  o_contrast_level;
    logic        o_contrast_changed;
    logic [1:0]  o_shift_3d;
    logic [4:0]  o_image_unit_select;
    logic        o_sram_enable_update;
    logic        o_sram_write_enable;
    logic        o_control_update;
    logic        o_keyboard_send_wait;
    logic        o_hrl_drive;
    logic        o_power_off;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MACHINE_TYPE;
    logic [7:0]  i_cfg_data = 8'h00;

    // Shadow copy of the block's state and configuration
    logic [3:0] shadow_contrast = '0;
    logic [1:0] shadow_shift = '0;
    logic [4:0] shadow_image = '0;
    logic [1:0] power_step = SEQ_IDLE;
    logic [1:0] version_step = SEQ_IDLE;
    logic [1:0] cfg_machine = MT_DISK_MODEL;
    logic [7:0] cfg_major = '0;
    logic [7:0] cfg_minor = '0;

    t_access       access_backlog[$];
    t_port_outcome awaited_outcomes[$];

    int fail_count = 0;
    int queued_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int version_byte_count = 0;
    int power_off_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    system_port_register_block_top uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_cmd                (held_access.cmd),
        .i_word_access        (held_access.word_access),
        .i_addr_low           (held_access.addr_low),
        .i_write_data         (held_access.write_data),
        .i_keyboard_connected (held_access.keyboard_connected),
        .i_hrl_status         (held_access.hrl_status),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_read_data          (o_read_data),
        .o_contrast_level     (o_contrast_level),
        .o_contrast_changed   (o_contrast_changed),
        .o_shift_3d           (o_shift_3d),
        .o_image_unit_select  (o_image_unit_select),
        .o_sram_enable_update (o_sram_enable_update),
        .o_sram_write_enable  (o_sram_write_enable),
        .o_control_update     (o_control_update),
        .o_keyboard_send_wait (o_keyboard_send_wait),
        .o_hrl_drive          (o_hrl_drive),
        .o_power_off          (o_power_off),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one access to the shadow state and return what the block should report
    function automatic t_port_outcome apply_access(input t_access acc);
        t_port_outcome res;
        logic [3:0]    addr;
        logic [7:0]    rbyte;
        logic [3:0]    nib;
        t_reg_sel      sel;
        res = '0;
        // a word access always lands on the odd byte
        addr = acc.addr_low | {3'b000, acc.word_access};
        sel = t_reg_sel'(addr[3:1]);
        nib = acc.write_data[3:0];
        if (acc.cmd == CMD_READ) begin
            rbyte = BYTE_IDLE;
            if (addr[0]) begin
                case (sel)
                    REG_CONTRAST: rbyte = CONTRAST_HIGH | {4'h0, shadow_contrast};
                    REG_SHIFT_3D: rbyte = SHIFT_HIGH | {6'h00, shadow_shift};
                    REG_CONTROL: begin
                        rbyte = CONTROL_HIGH |
                            {4'h0, acc.keyboard_connected, 1'b0, acc.hrl_status, 1'b0};
                    end
                    REG_MACHINE: begin
                        if (cfg_machine == MT_CLOCK_MODEL) rbyte = MACHINE_CLOCK;
                        else if (cfg_machine == MT_030_MODEL) rbyte = MACHINE_030;
                    end
                    REG_SRAM_VER: begin
                        // advance the version readout, byte or word alike
                        if (version_step != SEQ_IDLE) version_byte_count++;
                        case (version_step)
                            SEQ_ONE: begin
                                rbyte = VERSION_TAG;
                                version_step = SEQ_TWO;
                            end
                            SEQ_TWO: begin
                                rbyte = cfg_major;
                                version_step = SEQ_THREE;
                            end
                            SEQ_THREE: begin
                                rbyte = cfg_minor;
                                version_step = SEQ_IDLE;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            res.read_data = acc.word_access ? {WORD_HIGH, rbyte} : {8'h00, rbyte};
        end else if (addr[0]) begin
            case (sel)
                REG_CONTRAST: begin
                    if (shadow_contrast != nib) begin
                        shadow_contrast = nib;
                        res.contrast_changed = 1'b1;
                    end
                end
                REG_SHIFT_3D: shadow_shift = acc.write_data[1:0];
                REG_CONTROL: begin
                    res.control_update = 1'b1;
                    res.keyboard_send_wait = ~acc.write_data[3];
                    res.hrl_drive = acc.write_data[1];
                end
                REG_IMAGE_UNIT: shadow_image = acc.write_data[4:0];
                REG_SRAM_VER: begin
                    res.sram_enable_update = 1'b1;
                    res.sram_write_enable = (acc.write_data == SRAM_UNLOCK);
                    version_step = (acc.write_data == VERSION_START) ? SEQ_ONE : SEQ_IDLE;
                end
                REG_POWER: begin
                    case (power_step)
                        SEQ_IDLE: power_step = (nib == POWER_NIB_ZERO) ? SEQ_ONE : SEQ_IDLE;
                        SEQ_ONE:  power_step = (nib == POWER_NIB_F) ? SEQ_TWO : SEQ_IDLE;
                        SEQ_TWO: begin
                            if (nib == POWER_NIB_F) begin
                                power_step = SEQ_THREE;
                                res.power_off = 1'b1;
                            end else begin
                                power_step = SEQ_IDLE;
                            end
                        end
                        default: ;  // sequence done: hold until reset
                    endcase
                end
                default: ;  // spare and machine-type registers ignore writes
            endcase
        end
        res.contrast_level = shadow_contrast;
        res.shift_3d = shadow_shift;
        res.image_unit_select = shadow_image;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Present queued access items; predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_outcomes.push_back(apply_access(held_access));
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (access_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_access <= access_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_port_outcome want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result item with no access awaiting it");
                    fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("contrast_level", 16'(want.contrast_level),
                                16'(o_contrast_level));
                    check_field("contrast_changed", 16'(want.contrast_changed),
                                16'(o_contrast_changed));
                    check_field("shift_3d", 16'(want.shift_3d), 16'(o_shift_3d));
                    check_field("image_unit_select", 16'(want.image_unit_select),
                                16'(o_image_unit_select));
                    check_field("sram_enable_update", 16'(want.sram_enable_update),
                                16'(o_sram_enable_update));
                    check_field("sram_write_enable", 16'(want.sram_write_enable),
                                16'(o_sram_write_enable));
                    check_field("control_update", 16'(want.control_update),
                                16'(o_control_update));
                    check_field("keyboard_send_wait", 16'(want.keyboard_send_wait),
                                16'(o_keyboard_send_wait));
                    check_field("hrl_drive", 16'(want.hrl_drive), 16'(o_hrl_drive));
                    check_field("power_off", 16'(want.power_off), 16'(o_power_off));
                    checked_count++;
                    if (o_power_off) power_off_count++;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_access(input logic cmd, input logic word, input logic [3:0] addr,
                              input logic [7:0] data, input logic kb, input logic hrl);
        t_access acc;
        acc.cmd = cmd;
        acc.word_access = word;
        acc.addr_low = addr;
        acc.write_data = data;
        acc.keyboard_connected = kb;
        acc.hrl_status = hrl;
        access_backlog.push_back(acc);
        queued_count++;
    endtask

    // Target a register by byte access at its odd address or word access at either
    task automatic add_reg_access(input logic cmd, input t_reg_sel sel, input logic [7:0] data);
        logic word;
        logic lsb;
        word = 1'($urandom_range(1));
        lsb = 1'($urandom_range(1));
        add_access(cmd, word, {sel, word ? lsb : 1'b1}, data,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Write data leaning toward the values the block decodes specially
    function automatic logic [7:0] pick_write_byte();
        logic [7:0] r;
        r = 8'($urandom);
        case ($urandom_range(7))
            0: return SRAM_UNLOCK;
            1: return VERSION_START;
            2: return {r[7:4], POWER_NIB_ZERO};
            3: return {r[7:4], POWER_NIB_F};
            default: return r;
        endcase
    endfunction

    task automatic queue_random_accesses(input int count);
        int         target;
        int         reads;
        logic [7:0] d;
        logic [3:0] nib;
        logic [2:0] s;
        t_reg_sel   sel;
        target = queued_count + count;
        while (queued_count < target) begin
            s = 3'($urandom_range(7));
            sel = t_reg_sel'(s);
            case ($urandom_range(9))
                0, 1, 2: begin
                    // any access anywhere in the window
                    add_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                               4'($urandom_range(15)), pick_write_byte(),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                3, 4: add_reg_access(1'($urandom_range(1)), sel, pick_write_byte());
                5, 6: begin
                    // version readout, sometimes cut short or disturbed
                    add_reg_access(CMD_WRITE, REG_SRAM_VER, VERSION_START);
                    reads = $urandom_range(4);
                    repeat (reads) begin
                        if ($urandom_range(3) == 0) begin
                            s = 3'($urandom_range(7));
                            add_reg_access(1'($urandom_range(1)), t_reg_sel'(s),
                                           pick_write_byte());
                        end
                        add_reg_access(CMD_READ, REG_SRAM_VER, 8'($urandom));
                    end
                end
                7: begin
                    // power sequence broken at the second or third nibble
                    d = 8'($urandom);
                    add_reg_access(CMD_WRITE, REG_POWER, {d[7:4], POWER_NIB_ZERO});
                    if ($urandom_range(1)) begin
                        d = 8'($urandom);
                        add_reg_access(CMD_WRITE, REG_POWER, {d[7:4], POWER_NIB_F});
                    end
                    d = 8'($urandom);
                    nib = 4'($urandom_range(14));
                    add_reg_access(CMD_WRITE, REG_POWER, {d[7:4], nib});
                end
                8: begin
                    // write then read back contrast or control
                    sel = $urandom_range(1) ? REG_CONTROL : REG_CONTRAST;
                    add_reg_access(CMD_WRITE, sel, 8'($urandom));
                    add_reg_access(CMD_READ, sel, 8'($urandom));
                end
                default: begin
                    d = 8'($urandom);
                    add_reg_access(CMD_WRITE, REG_SRAM_VER,
                                   $urandom_range(1) ? SRAM_UNLOCK : d);
                end
            endcase
        end
    endtask

    // Hold until every queued item is accepted and every result has come back
    task automatic wait_port_quiet();
        while (access_backlog.size() != 0 || i_in_valid || awaited_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MACHINE_TYPE:  cfg_machine = val[1:0];
            CFG_VERSION_MAJOR: cfg_major = val;
            CFG_VERSION_MINOR: cfg_minor = val;
            default: ;
        endcase
    endtask

    // Drain, reconfigure and set the idling mix for the next stretch of items
    task automatic start_phase(input logic [1:0] mt, input logic [7:0] major,
                               input logic [7:0] minor, input int send_pct,
                               input int recv_pct);
        wait_port_quiet();
        write_cfg(CFG_MACHINE_TYPE, {6'h00, mt});
        write_cfg(CFG_VERSION_MAJOR, major);
        write_cfg(CFG_VERSION_MINOR, minor);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        start_phase(MT_SPARE_MODEL, 8'h00, 8'hff, 0, 0);
        // contrast change and rewrite of the same value, word read at even address
        add_access(CMD_WRITE, 1'b0, {REG_CONTRAST, 1'b1}, 8'hff, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_CONTRAST, 1'b1}, 8'h0f, 1'b1, 1'b1);
        add_access(CMD_READ, 1'b1, {REG_CONTRAST, 1'b0}, 8'h00, 1'b0, 1'b1);
        add_access(CMD_WRITE, 1'b1, {REG_SHIFT_3D, 1'b0}, 8'hff, 1'b1, 1'b0);
        add_access(CMD_READ, 1'b0, {REG_SHIFT_3D, 1'b1}, 8'hff, 1'b0, 1'b0);
        // even byte read and write, writes to the ignored registers
        add_access(CMD_READ, 1'b0, {REG_SHIFT_3D, 1'b0}, 8'h00, 1'b1, 1'b1);
        add_access(CMD_WRITE, 1'b0, {REG_CONTRAST, 1'b0}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_SPARE, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_MACHINE, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b0, {REG_MACHINE, 1'b1}, 8'h00, 1'b0, 1'b0);
        // control outputs and status read
        add_access(CMD_WRITE, 1'b0, {REG_CONTROL, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_CONTROL, 1'b1}, 8'hff, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b0, {REG_CONTROL, 1'b1}, 8'h00, 1'b1, 1'b1);
        add_access(CMD_READ, 1'b1, {REG_CONTROL, 1'b0}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_IMAGE_UNIT, 1'b1}, 8'hff, 1'b0, 1'b0);
        // unlock, then full version readout with a word access at an odd address
        add_access(CMD_WRITE, 1'b0, {REG_SRAM_VER, 1'b1}, SRAM_UNLOCK, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_SRAM_VER, 1'b1}, VERSION_START, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b0, {REG_SRAM_VER, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b1, {REG_SRAM_VER, 1'b0}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b1, {REG_SRAM_VER, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_READ, 1'b0, {REG_SRAM_VER, 1'b1}, 8'h00, 1'b0, 1'b0);
        // power sequence: wrong first nibble, broken second, broken third
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'h05, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'h10, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'h0e, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'h0f, 1'b0, 1'b0);
        add_access(CMD_WRITE, 1'b0, {REG_POWER, 1'b1}, 8'hf3, 1'b0, 1'b0);
        queue_random_accesses(120);

        start_phase(MT_CLOCK_MODEL, 8'hff, 8'h00, 79, 0);
        queue_random_accesses(140);
        start_phase(MT_030_MODEL, 8'($urandom), 8'($urandom), 0, 79);
        queue_random_accesses(140);
        start_phase(MT_DISK_MODEL, 8'($urandom), 8'($urandom), 37, 37);
        queue_random_accesses(140);
        start_phase(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 0, 0);
        queue_random_accesses(140);
        // reset the power count, complete the sequence, then show it stays done
        add_reg_access(CMD_WRITE, REG_POWER, 8'h05);
        add_reg_access(CMD_WRITE, REG_POWER, {4'ha, POWER_NIB_ZERO});
        add_reg_access(CMD_WRITE, REG_POWER, {4'h0, POWER_NIB_F});
        add_reg_access(CMD_WRITE, REG_POWER, {4'h5, POWER_NIB_F});
        add_reg_access(CMD_WRITE, REG_POWER, {4'h0, POWER_NIB_ZERO});
        add_reg_access(CMD_WRITE, REG_POWER, {4'hf, POWER_NIB_F});
        add_reg_access(CMD_WRITE, REG_POWER, {4'hf, POWER_NIB_F});
        add_reg_access(CMD_READ, REG_POWER, 8'h00);

        wait_port_quiet();
        repeat (8) @(negedge i_clk);
        $display("Checked %0d results of %0d accesses across five settings and idling mixes.",
                 checked_count, accepted_count);
        $display("Version bytes read back: %0d; power-off pulses: %0d.",
                 version_byte_count, power_off_count);
        if (fail_count == 0 && awaited_outcomes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
